// ----- hw/rtl/slsw_pkg.sv -----
// ----------------------------------------------------------------------------
// slsw_pkg
// Shared types and constants of the sensor limit sentry watchdog.
// ----------------------------------------------------------------------------
package slsw_pkg;

  localparam int OP_W       = 3;
  localparam int CH_W       = 4;
  localparam int IN_VAL_W   = 32;
  localparam int MASK_W     = 16;
  localparam int CNT8_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int CHCFG_W    = 5;
  localparam int CAUSE_W    = 2;

  localparam logic [OP_W-1:0] OP_SAMPLE = 3'd0;
  localparam logic [OP_W-1:0] OP_LIMITS = 3'd1;
  localparam logic [OP_W-1:0] OP_HEART  = 3'd2;
  localparam logic [OP_W-1:0] OP_TICK   = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STARTUP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_HEART = 2'd2;

  localparam logic [CHCFG_W-1:0] CHANNELS_RST  = 5'd16;
  localparam logic [CNT8_W-1:0]  STARTUP_RST   = 8'd10;
  localparam logic [CNT8_W-1:0]  MIN_HEART_RST = 8'd4;
  localparam logic [CNT8_W-1:0]  CNT8_MAX      = 8'hFF;

  localparam logic [CAUSE_W-1:0] CAUSE_NONE  = 2'd0;
  localparam logic [CAUSE_W-1:0] CAUSE_HEART = 2'd1;
  localparam logic [CAUSE_W-1:0] CAUSE_TRIP  = 2'd2;

  typedef struct packed {
    logic accept;
    logic load_imm;
    logic step;
    logic load_walk;
  } ctrl_cmd_t;

  typedef struct packed {
    logic needs_walk;
    logic last_step;
  } dp_status_t;

endpackage

// ----- hw/rtl/slsw_dp.sv -----
// ----------------------------------------------------------------------------
// slsw_dp
// Datapath: channel tables, trip masks, counters, configuration registers,
// the one-channel-per-cycle limit compare and the result register.
// ----------------------------------------------------------------------------
module slsw_dp import slsw_pkg::*; #(
  parameter int NUM_CHANNELS = 16,
  parameter int VALUE_BITS   = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ctrl_cmd_t                  cmd,
  output dp_status_t                 sts,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  input  logic [OP_W-1:0]            in_op,
  input  logic [CH_W-1:0]            in_channel,
  input  logic signed [IN_VAL_W-1:0] in_reading,
  input  logic signed [IN_VAL_W-1:0] in_low_limit,
  input  logic signed [IN_VAL_W-1:0] in_high_limit,
  output logic [MASK_W-1:0]          out_upper_tripped,
  output logic [MASK_W-1:0]          out_lower_tripped,
  output logic                       out_safe_mode,
  output logic [CAUSE_W-1:0]         out_cause
);

  localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int N_W   = 6;

  logic signed [VALUE_BITS-1:0] rd_q [NUM_CHANNELS];
  logic signed [VALUE_BITS-1:0] lo_q [NUM_CHANNELS];
  logic signed [VALUE_BITS-1:0] hi_q [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0]      vld_r;

  logic [MASK_W-1:0]  up_r, lw_r;
  logic [CNT8_W-1:0]  sec_r, hb_r;
  logic [IDX_W-1:0]   cnt_r;
  logic [CHCFG_W-1:0] chan_cfg_r;
  logic [CNT8_W-1:0]  startup_r, min_hb_r;

  logic [CNT8_W-1:0]       sec_inc;
  logic                    check, hb_low;
  logic [N_W-1:0]          n_eff;
  logic [IDX_W+CH_W-1:0]   ch_ext;
  logic [IDX_W-1:0]        ch_idx;
  logic                    ch_ok;
  logic [IDX_W+CH_W-1:0]   cnt_ext;
  logic [MASK_W-1:0]       bit_sel;
  logic signed [VALUE_BITS-1:0] sel_rd, sel_lo, sel_hi;
  logic signed [VALUE_BITS-1:0] new_lo, new_hi, new_rd;
  logic [VALUE_BITS:0]     lim_sum;
  logic [MASK_W-1:0]       up_imm, lw_imm;
  logic                    safe_imm;

  always_comb begin
    sec_inc  = (sec_r == CNT8_MAX) ? sec_r : sec_r + 8'd1;
    check    = sec_inc >= startup_r;
    hb_low   = hb_r < min_hb_r;
    n_eff    = ({1'b0, chan_cfg_r} > N_W'(NUM_CHANNELS)) ? N_W'(NUM_CHANNELS)
                                                         : {1'b0, chan_cfg_r};
    sts.needs_walk = (in_op == OP_TICK) && check && !hb_low && (n_eff != '0);
    sts.last_step  = (N_W'(cnt_r) + N_W'(1)) == n_eff;

    ch_ext  = {{IDX_W{1'b0}}, in_channel};
    ch_idx  = ch_ext[IDX_W-1:0];
    ch_ok   = ch_ext < (IDX_W+CH_W)'(NUM_CHANNELS);

    new_lo  = in_low_limit[VALUE_BITS-1:0];
    new_hi  = in_high_limit[VALUE_BITS-1:0];
    lim_sum = {new_lo[VALUE_BITS-1], new_lo} + {new_hi[VALUE_BITS-1], new_hi};
    new_rd  = lim_sum[VALUE_BITS:1];

    cnt_ext = {{CH_W{1'b0}}, cnt_r};
    bit_sel = (cnt_ext[IDX_W+CH_W-1:CH_W] == '0) ? (MASK_W'(1) << cnt_ext[CH_W-1:0])
                                                 : '0;
    sel_rd  = vld_r[cnt_r] ? rd_q[cnt_r] : '0;
    sel_lo  = vld_r[cnt_r] ? lo_q[cnt_r] : '0;
    sel_hi  = vld_r[cnt_r] ? hi_q[cnt_r] : '0;

    up_imm   = (in_op == OP_CLEAR) ? '0 : up_r;
    lw_imm   = (in_op == OP_CLEAR) ? '0 : lw_r;
    safe_imm = (in_op == OP_TICK) && check && hb_low;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r      <= '0;
      up_r       <= '0;
      lw_r       <= '0;
      sec_r      <= '0;
      hb_r       <= '0;
      cnt_r      <= '0;
      chan_cfg_r <= CHANNELS_RST;
      startup_r  <= STARTUP_RST;
      min_hb_r   <= MIN_HEART_RST;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_CHANNELS:  chan_cfg_r <= cfg_data[CHCFG_W-1:0];
          CFG_STARTUP:   startup_r  <= cfg_data;
          CFG_MIN_HEART: min_hb_r   <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.accept) begin
        cnt_r <= '0;
        case (in_op)
          OP_SAMPLE: if (ch_ok) vld_r[ch_idx] <= 1'b1;
          OP_LIMITS: if (ch_ok) vld_r[ch_idx] <= 1'b1;
          OP_HEART:  if (hb_r != CNT8_MAX) hb_r <= hb_r + 8'd1;
          OP_TICK: begin
            sec_r <= sec_inc;
            hb_r  <= '0;
          end
          OP_CLEAR: begin
            up_r <= '0;
            lw_r <= '0;
          end
          default: ;
        endcase
      end
      if (cmd.step) begin
        cnt_r <= IDX_W'(cnt_r + 1'b1);
        if (sel_rd > sel_hi) up_r <= up_r | bit_sel;
        if (sel_rd < sel_lo) lw_r <= lw_r | bit_sel;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && ch_ok) begin
      case (in_op)
        OP_SAMPLE: begin
          rd_q[ch_idx] <= in_reading[VALUE_BITS-1:0];
          if (!vld_r[ch_idx]) begin
            lo_q[ch_idx] <= '0;
            hi_q[ch_idx] <= '0;
          end
        end
        OP_LIMITS: begin
          rd_q[ch_idx] <= new_rd;
          lo_q[ch_idx] <= new_lo;
          hi_q[ch_idx] <= new_hi;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_imm) begin
      out_upper_tripped <= up_imm;
      out_lower_tripped <= lw_imm;
      out_safe_mode     <= safe_imm;
      out_cause         <= safe_imm ? CAUSE_HEART : CAUSE_NONE;
    end else if (cmd.load_walk) begin
      out_upper_tripped <= up_r;
      out_lower_tripped <= lw_r;
      out_safe_mode     <= (up_r != '0) || (lw_r != '0);
      out_cause         <= ((up_r != '0) || (lw_r != '0)) ? CAUSE_TRIP : CAUSE_NONE;
    end
  end

endmodule

// ----- hw/rtl/slsw_ctrl.sv -----
// ----------------------------------------------------------------------------
// slsw_ctrl
// Controller: input and result handshakes, channel walk sequencing and the
// result valid flag.
// ----------------------------------------------------------------------------
module slsw_ctrl import slsw_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  dp_status_t sts,
  output ctrl_cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  always_comb begin
    out_free      = !out_valid_r || !out_stall;
    in_stall      = (state_r != ST_IDLE) || !out_free;
    cmd           = '0;
    state_nxt     = state_r;
    case (state_r)
      ST_IDLE: begin
        cmd.accept   = in_valid && out_free;
        cmd.load_imm = cmd.accept && !sts.needs_walk;
        if (cmd.accept && sts.needs_walk) state_nxt = ST_WALK;
      end
      ST_WALK: begin
        cmd.step = 1'b1;
        if (sts.last_step) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        cmd.load_walk = out_free;
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
    out_valid_nxt = (out_valid_r && out_stall) || cmd.load_imm || cmd.load_walk;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_imm || cmd.load_walk) |-> (!out_valid_r || !out_stall))
    else $error("result register loaded while a result is still held");

  a_imm_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_imm |=> out_valid_r)
    else $error("single-cycle item produced no result");

  a_walk_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK && sts.last_step) |=> (state_r == ST_FIN))
    else $error("channel walk did not finish after its last channel");

  a_walk_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accept && sts.needs_walk) |=> (state_r == ST_WALK && !out_valid_nxt))
    else $error("tick with compare did not start the channel walk");

endmodule

// ----- hw/rtl/sensor_limit_sentry_watchdog.sv -----
// ----------------------------------------------------------------------------
// sensor_limit_sentry_watchdog
// Results: a sample, limit set, heartbeat, clear or uncompared tick is in the
//   output register in the cycle after acceptance; a compared tick first walks
//   n = min(channels_in_use, NUM_CHANNELS) channels, then waits for a free output.
// Throughput: one item per cycle while the output does not stall; compared ticks
//   hold the input while the single compare unit walks one channel a cycle.
// Reset (synchronous): tables read as zero, masks and counters clear, config
//   registers take their defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sensor_limit_sentry_watchdog import slsw_pkg::*; #(
  parameter int NUM_CHANNELS = 16,
  parameter int VALUE_BITS   = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [OP_W-1:0]            in_op,
  input  logic [CH_W-1:0]            in_channel,
  input  logic signed [IN_VAL_W-1:0] in_reading,
  input  logic signed [IN_VAL_W-1:0] in_low_limit,
  input  logic signed [IN_VAL_W-1:0] in_high_limit,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [MASK_W-1:0]          out_upper_tripped,
  output logic [MASK_W-1:0]          out_lower_tripped,
  output logic                       out_safe_mode,
  output logic [CAUSE_W-1:0]         out_cause,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data
);

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  assign cfg_ready = 1'b1;

  slsw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  slsw_dp #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .VALUE_BITS   (VALUE_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_we            (cfg_valid && cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_op             (in_op),
    .in_channel        (in_channel),
    .in_reading        (in_reading),
    .in_low_limit      (in_low_limit),
    .in_high_limit     (in_high_limit),
    .out_upper_tripped (out_upper_tripped),
    .out_lower_tripped (out_lower_tripped),
    .out_safe_mode     (out_safe_mode),
    .out_cause         (out_cause)
  );

endmodule

// ----- sim/slsw_sentry_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// slsw_sentry_checker
// Watches the input, result and configuration channels of the sentry
// watchdog, keeps its own copy of the tables, masks, counters and registers,
// predicts the status of every accepted transaction and compares each result
// field by field with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module slsw_sentry_checker import slsw_pkg::*; #(
  parameter int NUM_CHANNELS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic [OP_W-1:0]            in_op,
  input  logic [CH_W-1:0]            in_channel,
  input  logic signed [IN_VAL_W-1:0] in_reading,
  input  logic signed [IN_VAL_W-1:0] in_low_limit,
  input  logic signed [IN_VAL_W-1:0] in_high_limit,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic [MASK_W-1:0]          out_upper_tripped,
  input  logic [MASK_W-1:0]          out_lower_tripped,
  input  logic                       out_safe_mode,
  input  logic [CAUSE_W-1:0]         out_cause,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  output int                         fail_count,
  output int                         pending_count
);

  typedef struct packed {
    logic [MASK_W-1:0]  upper;
    logic [MASK_W-1:0]  lower;
    logic               safe;
    logic [CAUSE_W-1:0] cause;
  } trip_status_t;

  trip_status_t status_due[$];

  logic signed [IN_VAL_W-1:0] reading_tab [NUM_CHANNELS];
  logic signed [IN_VAL_W-1:0] low_tab     [NUM_CHANNELS];
  logic signed [IN_VAL_W-1:0] high_tab    [NUM_CHANNELS];
  logic [MASK_W-1:0]          upper_mask;
  logic [MASK_W-1:0]          lower_mask;
  logic [CNT8_W-1:0]          seconds;
  logic [CNT8_W-1:0]          beats;
  logic [CHCFG_W-1:0]         chans_cfg;
  logic [CNT8_W-1:0]          startup_cfg;
  logic [CNT8_W-1:0]          min_beats_cfg;
  int                         errors = 0;

  task automatic report(input string msg);
    errors++;
    if (errors <= 40) begin
      $display("%0t ns sentry mismatch: %s", $time, msg);
    end
  endtask

  task automatic advance_sentry(input logic [OP_W-1:0] op, input logic [CH_W-1:0] ch,
                                input logic signed [IN_VAL_W-1:0] rd,
                                input logic signed [IN_VAL_W-1:0] lo,
                                input logic signed [IN_VAL_W-1:0] hi,
                                output trip_status_t st);
    logic signed [IN_VAL_W:0] sum;
    int                       n;
    int                       i;
    st.safe  = 1'b0;
    st.cause = CAUSE_NONE;
    case (op)
      OP_SAMPLE: begin
        if (ch < NUM_CHANNELS) reading_tab[ch] = rd;
      end
      OP_LIMITS: begin
        if (ch < NUM_CHANNELS) begin
          // The midpoint is taken one bit wider so that it cannot overflow.
          sum = {lo[IN_VAL_W-1], lo} + {hi[IN_VAL_W-1], hi};
          low_tab[ch]     = lo;
          high_tab[ch]    = hi;
          reading_tab[ch] = sum[IN_VAL_W:1];
        end
      end
      OP_HEART: begin
        if (beats != CNT8_MAX) beats++;
      end
      OP_TICK: begin
        if (seconds != CNT8_MAX) seconds++;
        if (seconds >= startup_cfg) begin
          if (beats < min_beats_cfg) begin
            st.safe  = 1'b1;
            st.cause = CAUSE_HEART;
          end else if (chans_cfg != '0) begin
            n = (chans_cfg > NUM_CHANNELS) ? NUM_CHANNELS : int'(chans_cfg);
            for (i = 0; i < n; i++) begin
              if (i < MASK_W) begin
                if (reading_tab[i] > high_tab[i]) upper_mask[i] = 1'b1;
                if (reading_tab[i] < low_tab[i]) lower_mask[i] = 1'b1;
              end
            end
            if (upper_mask != '0 || lower_mask != '0) begin
              st.safe  = 1'b1;
              st.cause = CAUSE_TRIP;
            end
          end
        end
        beats = '0;
      end
      OP_CLEAR: begin
        upper_mask = '0;
        lower_mask = '0;
      end
      default: ;
    endcase
    st.upper = upper_mask;
    st.lower = lower_mask;
  endtask

  always @(posedge clk) begin : watch_channels
    trip_status_t want;
    trip_status_t made;
    int           i;
    if (!rst_n) begin
      for (i = 0; i < NUM_CHANNELS; i++) begin
        reading_tab[i] = '0;
        low_tab[i]     = '0;
        high_tab[i]    = '0;
      end
      upper_mask    = '0;
      lower_mask    = '0;
      seconds       = '0;
      beats         = '0;
      chans_cfg     = CHANNELS_RST;
      startup_cfg   = STARTUP_RST;
      min_beats_cfg = MIN_HEART_RST;
      status_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_CHANNELS:  chans_cfg     = cfg_data[CHCFG_W-1:0];
          CFG_STARTUP:   startup_cfg   = cfg_data;
          CFG_MIN_HEART: min_beats_cfg = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (status_due.size() == 0) begin
          report("result arrived with no transaction waiting for it");
        end else begin
          want = status_due.pop_front();
          if (out_upper_tripped !== want.upper) begin
            report($sformatf("upper_tripped %h, expected %h", out_upper_tripped, want.upper));
          end
          if (out_lower_tripped !== want.lower) begin
            report($sformatf("lower_tripped %h, expected %h", out_lower_tripped, want.lower));
          end
          if (out_safe_mode !== want.safe) begin
            report($sformatf("safe_mode %b, expected %b", out_safe_mode, want.safe));
          end
          if (out_cause !== want.cause) begin
            report($sformatf("cause %0d, expected %0d", out_cause, want.cause));
          end
        end
      end
      if (in_valid && !in_stall) begin
        advance_sentry(in_op, in_channel, in_reading, in_low_limit, in_high_limit, made);
        status_due.push_back(made);
      end
    end
    fail_count    <= errors;
    pending_count <= status_due.size();
  end

endmodule

// ----- sim/tb_sensor_limit_sentry_watchdog.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sensor_limit_sentry_watchdog
// Drives the sentry watchdog with a short directed sequence and then with
// random one-second frames (heartbeats, samples, limit sets, clears, a tick)
// under several register settings, with bursty input and a stalling result
// side. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_sensor_limit_sentry_watchdog;
  import slsw_pkg::*;

  localparam int     NUM_CH        = 16;
  localparam int     CLK_PERIOD    = 12;
  localparam int     RESET_CYCLES  = 7;
  localparam int     SETTLE_CYCLES = 40;
  localparam longint TIME_LIMIT_NS = 8_000_000;

  localparam logic signed [IN_VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [IN_VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic [OP_W-1:0]            OP_SPARE_LO = 3'd5;
  localparam logic [OP_W-1:0]            OP_SPARE_HI = 3'd7;

  typedef enum logic [1:0] {STALL_OFF, STALL_RANDOM, STALL_BURSTY, STALL_PERIODIC} stall_mode_t;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  logic [OP_W-1:0]            in_op;
  logic [CH_W-1:0]            in_channel;
  logic signed [IN_VAL_W-1:0] in_reading;
  logic signed [IN_VAL_W-1:0] in_low_limit;
  logic signed [IN_VAL_W-1:0] in_high_limit;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [MASK_W-1:0]          out_upper_tripped;
  logic [MASK_W-1:0]          out_lower_tripped;
  logic                       out_safe_mode;
  logic [CAUSE_W-1:0]         out_cause;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [CFG_DATA_W-1:0]      cfg_data;
  int                         fail_count;
  int                         pending_count;

  logic signed [IN_VAL_W-1:0] lim_lo [NUM_CH];
  logic signed [IN_VAL_W-1:0] lim_hi [NUM_CH];
  int                         items_sent   = 0;
  int                         ticks_sent   = 0;
  int                         burst_left   = 0;
  int                         gap_max      = 0;
  int                         beats_needed = 4;

  stall_mode_t                stall_mode      = STALL_OFF;
  int                         stall_mode_left = 0;
  int                         stall_hold      = 0;
  logic                       stall_level     = 1'b0;
  int unsigned                stall_tick      = 0;

  sensor_limit_sentry_watchdog dut (.*);

  slsw_sentry_checker #(.NUM_CHANNELS(NUM_CH)) sentry_chk (.*);

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(TIME_LIMIT_NS);
    $display("tb_sensor_limit_sentry_watchdog NOT OK");
    $finish;
  end

  always @(posedge clk) begin
    if (stall_mode_left == 0) begin
      stall_mode      = stall_mode_t'($urandom_range(0, int'(STALL_PERIODIC)));
      stall_mode_left = $urandom_range(40, 300);
    end
    stall_mode_left--;
    stall_tick++;
    case (stall_mode)
      STALL_OFF:    out_stall <= 1'b0;
      STALL_RANDOM: out_stall <= ($urandom_range(0, 99) < 30);
      STALL_BURSTY: begin
        if (stall_hold == 0) begin
          stall_hold  = $urandom_range(1, 12);
          stall_level = ~stall_level;
        end
        stall_hold--;
        out_stall <= stall_level;
      end
      default:      out_stall <= stall_tick[2];
    endcase
  end

  task automatic offer_item(input logic [OP_W-1:0] op, input logic [CH_W-1:0] ch,
                            input logic signed [IN_VAL_W-1:0] rd,
                            input logic signed [IN_VAL_W-1:0] lo,
                            input logic signed [IN_VAL_W-1:0] hi);
    int gap;
    if (burst_left == 0 && gap_max != 0) begin
      gap = $urandom_range(1, gap_max);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 16);
    end
    in_valid      <= 1'b1;
    in_op         <= op;
    in_channel    <= ch;
    in_reading    <= rd;
    in_low_limit  <= lo;
    in_high_limit <= hi;
    if (op == OP_LIMITS) begin
      lim_lo[ch] = lo;
      lim_hi[ch] = hi;
    end
    if (op <= OP_CLEAR) items_sent++;
    if (op == OP_TICK) ticks_sent++;
    do @(posedge clk); while (in_stall);
    if (burst_left > 0) burst_left--;
  endtask

  task automatic send_op(input logic [OP_W-1:0] op);
    offer_item(op, CH_W'($urandom), $urandom, $urandom, $urandom);
  endtask

  function automatic logic signed [IN_VAL_W-1:0] pick_reading(input int ch);
    logic signed [IN_VAL_W-1:0] lo;
    logic signed [IN_VAL_W-1:0] hi;
    lo = lim_lo[ch];
    hi = lim_hi[ch];
    case ($urandom_range(0, 5))
      0:       return $urandom;
      1:       return hi + 1;
      2:       return lo - 1;
      3:       return hi;
      4:       return lo;
      default: return lo + ((hi - lo) >>> 1);
    endcase
  endfunction

  task automatic send_other();
    int                         ch;
    int                         roll;
    logic signed [IN_VAL_W-1:0] lo;
    logic signed [IN_VAL_W-1:0] hi;
    ch   = $urandom_range(0, NUM_CH - 1);
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      offer_item(OP_SAMPLE, CH_W'(ch), pick_reading(ch), $urandom, $urandom);
    end else if (roll < 85) begin
      roll = $urandom_range(0, 9);
      lo   = $urandom;
      if (roll == 0) begin
        lo = VAL_MIN;
        hi = VAL_MAX;
      end else if (roll == 1) begin
        hi = $urandom;
      end else begin
        hi = lo + $signed(IN_VAL_W'($urandom_range(0, 32'h0004_0000)));
      end
      offer_item(OP_LIMITS, CH_W'(ch), $urandom, lo, hi);
    end else if (roll < 95) begin
      send_op(OP_CLEAR);
    end else begin
      send_op(OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)));
    end
  endtask

  // One second of traffic: mostly enough heartbeats, mixed with other work,
  // closed by a tick.
  task automatic run_second();
    int beats_left;
    int others_left;
    if (beats_needed > 0 && $urandom_range(0, 7) == 0) begin
      beats_left = $urandom_range(0, beats_needed - 1);
    end else begin
      beats_left = beats_needed + $urandom_range(0, 2);
    end
    others_left = $urandom_range(0, 4);
    while (beats_left + others_left > 0) begin
      if ($urandom_range(1, beats_left + others_left) <= beats_left) begin
        send_op(OP_HEART);
        beats_left--;
      end else begin
        send_other();
        others_left--;
      end
    end
    send_op(OP_TICK);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] chans,
                           input logic [CFG_DATA_W-1:0] startup,
                           input logic [CFG_DATA_W-1:0] min_beats);
    logic [CFG_IDX_W-1:0]  idx [3];
    logic [CFG_DATA_W-1:0] val [3];
    int                    k;
    idx = '{CFG_CHANNELS, CFG_STARTUP, CFG_MIN_HEART};
    val = '{chans, startup, min_beats};
    for (k = 0; k < 3; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    beats_needed = int'(min_beats);
  endtask

  task automatic run_phase(input int budget, input int gap);
    int goal;
    gap_max = gap;
    goal    = items_sent + budget;
    while (items_sent < goal) begin
      if ($urandom_range(0, 9) == 0) begin
        send_op(OP_W'($urandom_range(OP_SAMPLE, OP_SPARE_HI)));
      end else begin
        run_second();
      end
      if ($urandom_range(0, 99) == 0) drain();
    end
  endtask

  initial begin
    for (int i = 0; i < NUM_CH; i++) begin
      lim_lo[i] = '0;
      lim_hi[i] = '0;
    end
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_op         <= OP_SAMPLE;
    in_channel    <= '0;
    in_reading    <= '0;
    in_low_limit  <= '0;
    in_high_limit <= '0;
    cfg_valid     <= 1'b0;
    cfg_index     <= CFG_CHANNELS;
    cfg_data      <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Extreme and reversed limits, extreme samples, a tick inside the grace
    // period and the unused operation codes, all under the reset settings.
    gap_max = 3;
    offer_item(OP_LIMITS, 4'd15, '0, VAL_MIN, VAL_MAX);
    offer_item(OP_LIMITS, 4'd1, '0, VAL_MAX, VAL_MAX);
    offer_item(OP_LIMITS, 4'd2, '0, VAL_MIN, VAL_MIN);
    offer_item(OP_LIMITS, 4'd3, '0, 32'sd5, -32'sd5);
    offer_item(OP_SAMPLE, 4'd0, VAL_MAX, '0, '0);
    offer_item(OP_SAMPLE, 4'd4, VAL_MIN, '0, '0);
    send_op(OP_HEART);
    send_op(OP_TICK);
    send_op(OP_SPARE_LO);
    send_op(OP_SPARE_HI);
    send_op(OP_CLEAR);
    drain();

    // With no grace period: a missing heartbeat first, then real compares.
    configure(8'd16, 8'd0, 8'd2);
    send_op(OP_TICK);
    send_op(OP_HEART);
    send_op(OP_HEART);
    send_op(OP_TICK);
    send_op(OP_CLEAR);
    offer_item(OP_SAMPLE, 4'd0, '0, '0, '0);
    offer_item(OP_SAMPLE, 4'd4, '0, '0, '0);
    offer_item(OP_SAMPLE, 4'd3, 32'sd5, '0, '0);
    send_op(OP_HEART);
    send_op(OP_HEART);
    send_op(OP_TICK);
    drain();

    configure(CFG_DATA_W'(CHANNELS_RST), STARTUP_RST, MIN_HEART_RST);
    run_phase(100, 0);
    drain();
    configure(8'd0, 8'd0, 8'd0);
    run_phase(100, 6);
    drain();
    configure(8'd5, 8'd2, 8'd1);
    run_phase(100, 3);
    drain();
    configure(8'd1, 8'd3, 8'd8);
    run_phase(100, 10);
    drain();

    // Enough ticks to saturate the second counter, all channels clamped.
    configure(8'hFF, 8'h00, 8'h00);
    gap_max = 4;
    while (ticks_sent < 280) begin
      if ($urandom_range(0, 3) == 0) send_other();
      else send_op(OP_TICK);
    end
    drain();

    // The heartbeat counter saturates exactly at the largest requirement.
    configure(8'd16, 8'hFF, 8'hFF);
    gap_max = 2;
    repeat (260) send_op(OP_HEART);
    send_op(OP_TICK);
    send_op(OP_TICK);
    drain();

    configure(8'hE7, 8'd200, 8'd3);
    run_phase(100, 5);
    drain();
    configure(8'd17, 8'd1, 8'd2);
    run_phase(100, 2);
    drain();
    configure(8'd15, 8'd1, 8'd2);
    run_phase(100, 0);
    drain();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_sensor_limit_sentry_watchdog OK");
    end else begin
      $display("tb_sensor_limit_sentry_watchdog NOT OK");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/slsw_pkg.sv
hw/rtl/slsw_dp.sv
hw/rtl/slsw_ctrl.sv
hw/rtl/sensor_limit_sentry_watchdog.sv
sim/slsw_sentry_checker.sv
sim/tb_sensor_limit_sentry_watchdog.sv
